// File: rtl/mbtd_pkg.sv
// ----------------------------------------------------------------------------
// mbtd_pkg
// Types and constants shared by the timed button debounce block.
// ----------------------------------------------------------------------------
package mbtd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;
  localparam int INDEX_W    = 7;
  localparam int KIND_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTARY_PRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTARY_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT       = 3'd5;

  localparam logic [KIND_W-1:0] KIND_PLAIN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ANALOG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROTARY = 2'd2;

  localparam logic [1:0] ONE_SHOT_PERIODS = 2'd3;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] analog_press_ms;
    logic [15:0] analog_min_ms;
    logic [15:0] rotary_press_ms;
    logic [15:0] rotary_min_ms;
    logic [7:0]  report_period_ms;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic deb;
    logic prev;
  } flags_t;

  typedef struct packed {
    logic [TIME_W-1:0] edge_time;
    flags_t            flags;
  } entry_t;

endpackage

// File: rtl/mbtd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbtd_cfg_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module mbtd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbtd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mbtd_pkg::cfg_t                  cfg
);
  import mbtd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:     cfg_nxt.debounce_ms      = cfg_wdata;
        REG_ANALOG_PRESS: cfg_nxt.analog_press_ms  = cfg_wdata;
        REG_ANALOG_MIN:   cfg_nxt.analog_min_ms    = cfg_wdata;
        REG_ROTARY_PRESS: cfg_nxt.rotary_press_ms  = cfg_wdata;
        REG_ROTARY_MIN:   cfg_nxt.rotary_min_ms    = cfg_wdata;
        REG_REPORT:       cfg_nxt.report_period_ms = cfg_wdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= 16'd50;
      cfg_r.analog_press_ms  <= 16'd0;
      cfg_r.analog_min_ms    <= 16'd0;
      cfg_r.rotary_press_ms  <= 16'd0;
      cfg_r.rotary_min_ms    <= 16'd0;
      cfg_r.report_period_ms <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/mbtd_state_mem.sv
// ----------------------------------------------------------------------------
// mbtd_state_mem
// Per-button entry memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module mbtd_state_mem #(
  parameter int NUM_BUTTONS = 128,
  parameter int AW          = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output mbtd_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  mbtd_pkg::entry_t     wr_data
);
  import mbtd_pkg::*;

  entry_t                 mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] valid_r;
  entry_t                 q_r;
  logic                   q_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // unwritten entries read as cleared flags
  always_comb begin
    rd_data.edge_time = q_r.edge_time;
    rd_data.flags     = q_valid_r ? q_r.flags : '0;
  end

endmodule

// File: rtl/mbtd_update.sv
// ----------------------------------------------------------------------------
// mbtd_update
// Next-state logic for one button entry from one raw sample.
// ----------------------------------------------------------------------------
module mbtd_update (
  input  mbtd_pkg::cfg_t                  cfg,
  input  mbtd_pkg::entry_t                cur,
  input  logic                            level,
  input  logic [mbtd_pkg::KIND_W-1:0]     kind,
  input  logic                            one_shot,
  input  logic [mbtd_pkg::TIME_W-1:0]     now_ms,
  output mbtd_pkg::entry_t                nxt
);
  import mbtd_pkg::*;

  logic [15:0]       press_lim;
  logic [15:0]       min_lim;
  logic [9:0]        shot_lim;
  logic [TIME_W-1:0] t0;
  logic [TIME_W-1:0] d0;
  logic [TIME_W-1:0] d1;
  logic              hi0;
  logic              gt_press;
  logic              gt_deb;
  logic              gt_min;
  logic              gt_shot;
  logic              set_deb;
  flags_t            f;

  always_comb begin
    case (kind)
      KIND_ANALOG: begin
        press_lim = cfg.analog_press_ms;
        min_lim   = cfg.analog_min_ms;
      end
      KIND_ROTARY: begin
        press_lim = cfg.rotary_press_ms;
        min_lim   = cfg.rotary_min_ms;
      end
      default: begin
        press_lim = 16'd0;
        min_lim   = 16'd0;
      end
    endcase
  end

  assign shot_lim = 10'(cfg.report_period_ms) * 10'(ONE_SHOT_PERIODS);

  always_comb begin
    f        = cur.flags;
    t0       = cur.flags.prev ? cur.edge_time : now_ms;
    d0       = now_ms - t0;
    hi0      = |d0[TIME_W-1:16];
    gt_press = hi0 || (d0[15:0] > press_lim);
    gt_deb   = hi0 || (d0[15:0] > cfg.debounce_ms);
    gt_min   = hi0 || (d0[15:0] > min_lim);
    nxt.edge_time = t0;
    set_deb  = 1'b0;
    d1       = d0;
    gt_shot  = 1'b0;
    if (level) begin
      if ((press_lim != 16'd0) && f.pressed && gt_press) begin
        f.pressed = 1'b0;
      end
      set_deb = f.prev && !f.deb && gt_deb && gt_min;
      if (set_deb) begin
        f.pressed     = 1'b1;
        f.deb         = 1'b1;
        nxt.edge_time = now_ms;
        d1            = '0;
      end
      gt_shot = (|d1[TIME_W-1:10]) || (d1[9:0] > shot_lim);
      if (one_shot && f.pressed && gt_shot) begin
        f.pressed = 1'b0;
      end
      f.prev = 1'b1;
    end else begin
      f = '0;
    end
    nxt.flags = f;
  end

endmodule

// File: rtl/multi_button_timed_debounce.sv
// ----------------------------------------------------------------------------
// multi_button_timed_debounce
// Timestamp debounce for a bank of buttons, one raw sample per command.
// ----------------------------------------------------------------------------
// A sample is taken when start is high and busy is low. Each sample is a
// read-modify-write of the button's entry in the state memory: the accept
// cycle issues the read, the next cycle (busy high) updates and writes the
// entry back. The result is shown on out_index, out_pressed and out_debounced
// with out_strobe high for exactly one cycle, the cycle after busy, and must
// be taken then. A new sample may be started in that same cycle, but none
// while busy is high. State is ready right after reset; there is no clearing
// pass. The user must write configuration only while idle; not enforced here.
module multi_button_timed_debounce #(
  parameter int NUM_BUTTONS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbtd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic [mbtd_pkg::INDEX_W-1:0]    in_button_index,
  input  logic                            in_level,
  input  logic [mbtd_pkg::KIND_W-1:0]     in_kind,
  input  logic                            in_one_shot,
  input  logic [mbtd_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_strobe,
  output logic [mbtd_pkg::INDEX_W-1:0]    out_index,
  output logic                            out_pressed,
  output logic                            out_debounced
);
  import mbtd_pkg::*;

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  cfg_t                cfg;
  entry_t              cur;
  entry_t              nxt;
  logic                accept;
  logic [INDEX_W:0]    idx_ext;
  logic [AW-1:0]       rd_addr;
  logic                in_range;

  logic                busy_r;
  logic                in_range_r;
  logic [AW-1:0]       addr_r;
  logic [INDEX_W-1:0]  idx_r;
  logic                level_r;
  logic [KIND_W-1:0]   kind_r;
  logic                one_shot_r;
  logic [TIME_W-1:0]   now_r;

  logic                strobe_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic                pressed_r;
  logic                deb_r;

  assign accept   = start && !busy_r;
  assign idx_ext  = {1'b0, in_button_index};
  assign rd_addr  = idx_ext[AW-1:0];
  assign in_range = {2'b00, in_button_index} < 9'(NUM_BUTTONS);

  mbtd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbtd_state_mem #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (cur),
    .wr_en   (busy_r && in_range_r),
    .wr_addr (addr_r),
    .wr_data (nxt)
  );

  mbtd_update u_upd (
    .cfg      (cfg),
    .cur      (cur),
    .level    (level_r),
    .kind     (kind_r),
    .one_shot (one_shot_r),
    .now_ms   (now_r),
    .nxt      (nxt)
  );

  // captured sample
  always_ff @(posedge clk) begin
    if (accept) begin
      in_range_r <= in_range;
      addr_r     <= rd_addr;
      idx_r      <= in_button_index;
      level_r    <= in_level;
      kind_r     <= in_kind;
      one_shot_r <= in_one_shot;
      now_r      <= in_now_ms;
    end
    if (busy_r) begin
      out_index_r <= idx_r;
      pressed_r   <= in_range_r && nxt.flags.pressed;
      deb_r       <= in_range_r && nxt.flags.deb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= accept;
      strobe_r <= busy_r;
    end
  end

  assign busy          = busy_r;
  assign out_strobe    = strobe_r;
  assign out_index     = out_index_r;
  assign out_pressed   = pressed_r;
  assign out_debounced = deb_r;

endmodule

// File: rtl/mbtd_checker.sv
// ----------------------------------------------------------------------------
// mbtd_checker
// Port-level checks on command timing and result beats, bound to the top.
// ----------------------------------------------------------------------------
module mbtd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [mbtd_pkg::INDEX_W-1:0] in_button_index,
  input logic                         out_strobe,
  input logic [mbtd_pkg::INDEX_W-1:0] out_index,
  input logic                         out_pressed,
  input logic                         out_debounced
);
  import mbtd_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted sample did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_busy_beat: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("no result beat after update cycle");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(rst_n, 2)) |-> (out_index == $past(in_button_index, 2)))
    else $error("result beat carries wrong index");

  a_press_deb: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!out_pressed || out_debounced))
    else $error("pressed reported without debounced");

endmodule

bind multi_button_timed_debounce mbtd_checker u_mbtd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_button_index (in_button_index),
  .out_strobe      (out_strobe),
  .out_index       (out_index),
  .out_pressed     (out_pressed),
  .out_debounced   (out_debounced)
);
